>>> sv/wps_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser package
// Word types, error codes and chunk tags shared by the parser modules.
// ----------------------------------------------------------------------------
package wps_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic               is_status;
    logic signed [15:0] pcm_sample;
    logic               chunk_start;
    logic [3:0]         error_code;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [29:0]        sample_total;
    logic               final_res;
  } out_word_t;

  // One parsed byte can give a sample, a status, or both (sample first).
  typedef struct packed {
    logic               has_sample;
    logic signed [15:0] sample;
    logic               chunk_start;
    logic               has_status;
    logic [3:0]         error_code;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [29:0]        sample_total;
  } rec_t;

  typedef enum logic [3:0] {
    ERR_OK          = 4'd0,
    ERR_SHORT       = 4'd1,
    ERR_NOT_RIFF    = 4'd2,
    ERR_NOT_WAVE    = 4'd3,
    ERR_FMT_SHORT   = 4'd4,
    ERR_FORMAT      = 4'd5,
    ERR_BITS        = 4'd6,
    ERR_ZERO_CHAN   = 4'd7,
    ERR_ZERO_RATE   = 4'd8,
    ERR_NO_FMT      = 4'd9,
    ERR_NO_DATA     = 4'd10,
    ERR_DATA_EMPTY  = 4'd11
  } err_t;

  localparam logic [3:0][7:0] TAG_RIFF = {8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [3:0][7:0] TAG_WAVE = {8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [31:0] ID_FMT  = 32'h666D7420;
  localparam logic [31:0] ID_DATA = 32'h64617461;
  localparam logic [29:0] SAMPLES_MAX = 30'h3FFFFFFF;
  localparam logic [3:0] HEADER_LEN = 4'd12;
  localparam logic [3:0] CHUNK_HDR_LEN = 4'd8;
  localparam logic [4:0] FMT_LEN = 5'd16;
  localparam logic [15:0] PCM_FORMAT = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;

endpackage

>>> sv/wav_pcm16_stream_parser.sv
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser
// Parses a WAV file byte stream into signed 16-bit samples and a final status.
// ----------------------------------------------------------------------------
// The input side is a queue: write one file byte with its end-of-file flag
// while full is low by raising push. The result side is a queue as well: while
// empty is low the oldest result word is on result, and pop takes it.
// Each byte is parsed in the cycle it is accepted, so one byte per cycle is
// taken as long as the record queue has room. A byte that completes a sample
// or ends the file writes one record, registered in the queue before it shows.
// The result side emits one word per cycle, so a final byte that also closes a
// sample needs two pops for its record. Throughput is one byte per cycle in and
// one word per cycle out, with DEPTH records buffered between the two sides.
// When the receiver stalls, the queue fills and full rises; bytes then wait.
// Reset empties the queue and returns the parser to the start of a file; the
// end-of-file byte does the same for the parser after its status is queued.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  wps_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output wps_pkg::out_word_t result
);

  logic          accept;
  logic          rec_valid;
  wps_pkg::rec_t rec;
  wps_pkg::rec_t head;
  logic          head_pop;

  assign accept = push && !full;

  wps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  wps_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && rec_valid),
    .wr_data (rec),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  wps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (empty),
    .pop        (pop),
    .head_pop   (head_pop),
    .result     (result)
  );

endmodule

>>> sv/wps_front.sv
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser front end
// Walks the RIFF header and chunk headers, checks the fmt chunk, skips other
// chunks and pairs payload bytes into samples, one byte per cycle when accepted.
// ----------------------------------------------------------------------------
module wps_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  wps_pkg::in_word_t item,
  output logic             rec_valid,
  output wps_pkg::rec_t    rec
);

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_CHDR = 5'b00010,
    PH_FMT  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_t;

  phase_t          phase, phase_next;
  logic [3:0]      byte_pos, byte_pos_next;
  logic [1:0]      mismatch, mismatch_next;
  logic [31:0]     chunk_id, chunk_id_next;
  logic [31:0]     chunk_size, chunk_size_next;
  logic [32:0]     remaining, remaining_next;
  logic [15:0][7:0] fmt_bytes, fmt_bytes_next;
  logic [4:0]      fmt_off, fmt_off_next;
  logic            have_format, have_format_next;
  logic            have_payload, have_payload_next;
  logic            held_valid, held_valid_next;
  logic [7:0]      held_byte, held_byte_next;
  logic [3:0]      err, err_next;
  logic [29:0]     samples, samples_next;
  logic [3:0]      final_err;
  logic [7:0]      b;

  assign b = item.file_byte;

  always_comb begin
    phase_next        = phase;
    byte_pos_next     = byte_pos;
    mismatch_next     = mismatch;
    chunk_id_next     = chunk_id;
    chunk_size_next   = chunk_size;
    remaining_next    = remaining;
    fmt_bytes_next    = fmt_bytes;
    fmt_off_next      = fmt_off;
    have_format_next  = have_format;
    have_payload_next = have_payload;
    held_valid_next   = held_valid;
    held_byte_next    = held_byte;
    err_next          = err;
    samples_next      = samples;
    final_err         = wps_pkg::ERR_OK;
    rec               = '0;
    if (accept && err == wps_pkg::ERR_OK) begin
      case (phase)
        PH_RIFF: begin
          if (byte_pos < 4'd4 && b != wps_pkg::TAG_RIFF[2'd3 - byte_pos[1:0]]) begin
            mismatch_next[0] = 1'b1;
          end
          if (byte_pos >= 4'd8 && b != wps_pkg::TAG_WAVE[2'd3 - byte_pos[1:0]]) begin
            mismatch_next[1] = 1'b1;
          end
          byte_pos_next = byte_pos + 4'd1;
          if (byte_pos_next == wps_pkg::HEADER_LEN) begin
            if (mismatch_next[0]) begin
              err_next = wps_pkg::ERR_NOT_RIFF;
            end else if (mismatch_next[1]) begin
              err_next = wps_pkg::ERR_NOT_WAVE;
            end
            phase_next    = PH_CHDR;
            byte_pos_next = '0;
          end
        end
        PH_CHDR: begin
          if (byte_pos < 4'd4) begin
            chunk_id_next = {chunk_id[23:0], b};
          end else begin
            chunk_size_next = {b, chunk_size[31:8]};
          end
          byte_pos_next = byte_pos + 4'd1;
          if (byte_pos_next == wps_pkg::CHUNK_HDR_LEN) begin
            remaining_next  = {1'b0, chunk_size_next} + {32'd0, chunk_size_next[0]};
            held_valid_next = 1'b0;
            fmt_off_next    = '0;
            if (chunk_id == wps_pkg::ID_FMT) begin
              phase_next = PH_FMT;
              if (chunk_size_next < 32'(wps_pkg::FMT_LEN)) begin
                err_next = wps_pkg::ERR_FMT_SHORT;
              end
            end else if (chunk_id == wps_pkg::ID_DATA) begin
              phase_next        = PH_DATA;
              have_payload_next = 1'b1;
              samples_next      = '0;
            end else begin
              phase_next = PH_SKIP;
            end
            if (chunk_size_next == 32'd0 && err_next == wps_pkg::ERR_OK) begin
              phase_next    = PH_CHDR;
              byte_pos_next = '0;
            end
          end
        end
        PH_FMT, PH_DATA, PH_SKIP: begin
          remaining_next = remaining - 33'd1;
          if (phase == PH_FMT && fmt_off < wps_pkg::FMT_LEN) begin
            fmt_bytes_next[fmt_off[3:0]] = b;
            fmt_off_next = fmt_off + 5'd1;
            if (fmt_off == wps_pkg::FMT_LEN - 5'd1) begin
              if ({fmt_bytes_next[1], fmt_bytes_next[0]} != wps_pkg::PCM_FORMAT) begin
                err_next = wps_pkg::ERR_FORMAT;
              end else if ({fmt_bytes_next[15], fmt_bytes_next[14]} != wps_pkg::PCM_BITS) begin
                err_next = wps_pkg::ERR_BITS;
              end else if ({fmt_bytes_next[3], fmt_bytes_next[2]} == 16'd0) begin
                err_next = wps_pkg::ERR_ZERO_CHAN;
              end else if ({fmt_bytes_next[7], fmt_bytes_next[6],
                            fmt_bytes_next[5], fmt_bytes_next[4]} == 32'd0) begin
                err_next = wps_pkg::ERR_ZERO_RATE;
              end else begin
                have_format_next = 1'b1;
              end
            end
          end else if (phase == PH_DATA && remaining > {32'd0, chunk_size[0]}) begin
            if (held_valid) begin
              rec.has_sample  = 1'b1;
              rec.sample      = {b, held_byte};
              rec.chunk_start = (samples == 30'd0);
              if (samples < wps_pkg::SAMPLES_MAX) begin
                samples_next = samples + 30'd1;
              end
              held_valid_next = 1'b0;
            end else begin
              held_valid_next = 1'b1;
              held_byte_next  = b;
            end
          end
          if (remaining == 33'd1) begin
            phase_next      = PH_CHDR;
            byte_pos_next   = '0;
            held_valid_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (accept && item.end_of_file) begin
      if (err_next != wps_pkg::ERR_OK) begin
        final_err = err_next;
      end else if (phase_next == PH_RIFF) begin
        final_err = wps_pkg::ERR_SHORT;
      end else if (phase_next == PH_FMT && fmt_off_next < wps_pkg::FMT_LEN) begin
        final_err = wps_pkg::ERR_FMT_SHORT;
      end else if (!have_format_next) begin
        final_err = wps_pkg::ERR_NO_FMT;
      end else if (!have_payload_next) begin
        final_err = wps_pkg::ERR_NO_DATA;
      end else if (samples_next == 30'd0) begin
        final_err = wps_pkg::ERR_DATA_EMPTY;
      end
      rec.has_status = 1'b1;
      rec.error_code = final_err;
      if (final_err == wps_pkg::ERR_OK) begin
        rec.sample_rate   = {fmt_bytes_next[7], fmt_bytes_next[6],
                             fmt_bytes_next[5], fmt_bytes_next[4]};
        rec.channel_count = {fmt_bytes_next[3], fmt_bytes_next[2]};
        rec.sample_total  = samples_next;
      end
      phase_next        = PH_RIFF;
      byte_pos_next     = '0;
      mismatch_next     = '0;
      chunk_id_next     = '0;
      chunk_size_next   = '0;
      remaining_next    = '0;
      fmt_bytes_next    = '0;
      fmt_off_next      = '0;
      have_format_next  = 1'b0;
      have_payload_next = 1'b0;
      held_valid_next   = 1'b0;
      held_byte_next    = '0;
      err_next          = wps_pkg::ERR_OK;
      samples_next      = '0;
    end
  end

  assign rec_valid = rec.has_sample | rec.has_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RIFF;
      byte_pos     <= '0;
      mismatch     <= '0;
      chunk_id     <= '0;
      chunk_size   <= '0;
      remaining    <= '0;
      fmt_bytes    <= '0;
      fmt_off      <= '0;
      have_format  <= 1'b0;
      have_payload <= 1'b0;
      held_valid   <= 1'b0;
      held_byte    <= '0;
      err          <= wps_pkg::ERR_OK;
      samples      <= '0;
    end else begin
      phase        <= phase_next;
      byte_pos     <= byte_pos_next;
      mismatch     <= mismatch_next;
      chunk_id     <= chunk_id_next;
      chunk_size   <= chunk_size_next;
      remaining    <= remaining_next;
      fmt_bytes    <= fmt_bytes_next;
      fmt_off      <= fmt_off_next;
      have_format  <= have_format_next;
      have_payload <= have_payload_next;
      held_valid   <= held_valid_next;
      held_byte    <= held_byte_next;
      err          <= err_next;
      samples      <= samples_next;
    end
  end

endmodule

>>> sv/wps_fifo.sv
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser record queue
// Short queue of parsed records between the front end and the result side.
// ----------------------------------------------------------------------------
module wps_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  wps_pkg::rec_t wr_data,
  input  logic          rd_en,
  output wps_pkg::rec_t rd_data,
  output logic          full,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wps_pkg::rec_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> sv/wps_back.sv
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser result side
// Turns each queued record into one or two result words, sample first.
// ----------------------------------------------------------------------------
module wps_back (
  input  logic               clk,
  input  logic               rst,
  input  wps_pkg::rec_t      head,
  input  logic               head_empty,
  input  logic               pop,
  output logic               head_pop,
  output wps_pkg::out_word_t result
);

  logic sample_done;
  logic show_sample;
  logic taken;

  assign show_sample = head.has_sample && !sample_done;
  assign taken       = pop && !head_empty;
  assign head_pop    = taken && !(show_sample && head.has_status);

  always_comb begin
    result = '0;
    if (show_sample) begin
      result.pcm_sample  = head.sample;
      result.chunk_start = head.chunk_start;
    end else begin
      result.is_status     = 1'b1;
      result.error_code    = head.error_code;
      result.sample_rate   = head.sample_rate;
      result.channel_count = head.channel_count;
      result.sample_total  = head.sample_total;
      result.final_res     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_done <= 1'b0;
    end else if (taken) begin
      sample_done <= !head_pop;
    end
  end

endmodule
